// ===== src/kvt_pkg.sv =====
// Package for the key-value table: sizes, codes and beat types.
`default_nettype none
package kvt_pkg;

  // Number of entries in the table (row of cells)
  localparam int unsigned CAPACITY = 64;

  // Request action codes
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK              = 2'd0;
  localparam logic [1:0] ST_MISS_OR_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL            = 2'd2;

  // Request beat
  typedef struct packed {
    logic               action;
    logic signed [31:0] key;
    logic signed [31:0] value_in;
  } req_t;

  // Result beat
  typedef struct packed {
    logic               action_echo;
    logic signed [31:0] key_echo;
    logic [1:0]         status;
    logic signed [31:0] value_out;
  } rsp_t;

  // Request token handed from cell to cell along the row
  typedef struct packed {
    logic               vld;
    logic               action;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic               hit;
    logic signed [31:0] hit_value;
    logic               placed;
  } tok_t;

endpackage
`default_nettype wire

// ===== src/key_value_table_put_get_unit.sv =====
// Fully associative key-value table built as a row of entry cells.
//
// Usage: present a request on req and raise start; it is taken at a rising
// edge where start is high and busy is low. A request either looks up a key
// (action 0) or inserts key/value if the key is absent (action 1).
// The request travels down a row of CAPACITY cells, one cell per cycle; each
// cell compares its entry and the first free cell takes a pending insert.
// Entries fill from cell 0 upwards and are never removed.
// done rises once the token has left the last cell and passed the done
// register, carrying the result beat on rsp for that one cycle only.
// busy is low again in the cycle done is high, so a new request can be taken
// at the edge that ends it; a new request is not taken while the token of
// the last one is still walking along the row.
// Result: action and key echoed; status 0 success, 1 lookup miss or key
// already present, 2 table full; value_out the stored value on a lookup hit,
// the inserted value on insert success, else 0.
// Reset (rst, synchronous) clears every entry to invalid and drops busy and
// done. The receiver cannot stall: each result must be taken when shown.
`default_nettype none
module key_value_table_put_get_unit
  import kvt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output rsp_t      rsp
);

  tok_t tok [CAPACITY+1];
  logic accept;
  tok_t last;
  rsp_t rsp_next;

  assign accept = start && !busy;

  // Token entering cell 0 straight from the request port
  always_comb begin
    tok[0]           = '0;
    tok[0].vld       = accept;
    tok[0].action    = req.action;
    tok[0].key       = req.key;
    tok[0].value     = req.value_in;
    tok[0].hit       = 1'b0;
    tok[0].hit_value = '0;
    tok[0].placed    = 1'b0;
  end

  // Row of entry cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kvt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign last = tok[CAPACITY];

  // Resolve status and value from the token leaving the last cell
  always_comb begin
    rsp_next.action_echo = last.action;
    rsp_next.key_echo    = last.key;
    rsp_next.value_out   = '0;
    if (last.action == ACT_LOOKUP) begin
      if (last.hit) begin
        rsp_next.status    = ST_OK;
        rsp_next.value_out = last.hit_value;
      end else begin
        rsp_next.status = ST_MISS_OR_PRESENT;
      end
    end else if (last.hit) begin
      rsp_next.status = ST_MISS_OR_PRESENT;
    end else if (last.placed) begin
      rsp_next.status    = ST_OK;
      rsp_next.value_out = last.value;
    end else begin
      rsp_next.status = ST_FULL;
    end
  end

  // Busy flag, result strobe and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= last.vld;
      if (accept) begin
        busy <= 1'b1;
      end else if (last.vld) begin
        busy <= 1'b0;
      end
    end
    if (last.vld) begin
      rsp <= rsp_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/kvt_cell.sv =====
// One table entry: compares the passing token and takes an insert when free.
`default_nettype none
module kvt_cell
  import kvt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire tok_t tok_in,
  output tok_t      tok_out
);

  logic               valid;
  logic signed [31:0] key;
  logic signed [31:0] value;
  logic               match;
  logic               wr;
  tok_t               tok_next;

  // Compare against this entry; a free entry takes an unplaced insert
  always_comb begin
    match = valid && (key == tok_in.key) && !tok_in.hit;
    wr    = tok_in.vld && (tok_in.action == ACT_INSERT) && !valid
            && !tok_in.hit && !tok_in.placed;
    tok_next           = tok_in;
    tok_next.hit       = tok_in.hit | match;
    tok_next.hit_value = match ? value : tok_in.hit_value;
    tok_next.placed    = tok_in.placed | wr;
  end

  // Entry state: valid flag cleared at reset, key and value on write
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr) begin
      valid <= 1'b1;
    end
    if (wr) begin
      key   <= tok_in.key;
      value <= tok_in.value;
    end
  end

  // Hand the token on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.action    <= tok_next.action;
    tok_out.key       <= tok_next.key;
    tok_out.value     <= tok_next.value;
    tok_out.hit       <= tok_next.hit;
    tok_out.hit_value <= tok_next.hit_value;
    tok_out.placed    <= tok_next.placed;
  end

endmodule
`default_nettype wire

// ===== src/kvt_checker.sv =====
// Port-level checks on the key-value table, bound to the top level.
`default_nettype none
module kvt_checker
  import kvt_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire req_t req,
  input wire logic done,
  input wire rsp_t rsp
);

  // A taken request holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted request");

  // A result only closes a request that was in flight
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result beat without a request in flight");

  // One result beat per request
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // Status code is one of the defined ones
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == ST_OK || rsp.status == ST_MISS_OR_PRESENT
              || rsp.status == ST_FULL))
    else $error("undefined status code");

  // Failed requests carry a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.value_out == '0))
    else $error("non-zero value on a failed request");

endmodule

bind key_value_table_put_get_unit kvt_checker u_kvt_checker (.*);
`default_nettype wire
